[hdl/dhti_pkg.sv]
// shared types and constants for the double hashing insert block
// no dependencies; every other file refers to it by scoped names

package dhti_pkg;

  localparam int KEY_W    = 31;
  localparam int STATUS_W = 2;
  localparam int FIELD_W  = 6;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic                clear_wr;
    logic                load_key;
    logic                hash_start;
    logic                take_hash;
    logic                reduce_start;
    logic                take_step;
    logic                probe_start;
    logic                probe_next;
    logic                write_slot;
    logic                result_load;
    logic [STATUS_W-1:0] result_status;
    logic                out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic mod_done;
    logic need_reduce;
    logic hit_empty;
    logic hit_match;
    logic probe_last;
  } stat_t;

endpackage

[hdl/dhti_key_if.sv]
// channel carrying one key to insert
// depends on dhti_pkg for the key width

interface dhti_key_if;
  logic                        valid;
  logic                        ready;
  logic [dhti_pkg::KEY_W-1:0]  insert_key;

  modport source (output valid, output insert_key, input ready);
  modport sink   (input valid, input insert_key, output ready);
endinterface

[hdl/dhti_result_if.sv]
// channel carrying one insert result: status, slot and probe count
// depends on dhti_pkg for the field widths

interface dhti_result_if;
  logic                           valid;
  logic                           ready;
  logic [dhti_pkg::STATUS_W-1:0]  status;
  logic [dhti_pkg::FIELD_W-1:0]   slot_index;
  logic [dhti_pkg::FIELD_W-1:0]   probe_count;

  modport source (output valid, output status, output slot_index, output probe_count,
                  input ready);
  modport sink   (input valid, input status, input slot_index, input probe_count,
                  output ready);
endinterface

[hdl/dhti_mod_unit.sv]
// remainder unit: dividend mod TABLE_SIZE and mod STEP_PRIME by reciprocal multiplication
// three-stage pipeline, done pulses when the remainders are registered; depends on dhti_pkg

module dhti_mod_unit #(
  parameter int TABLE_SIZE = 61,
  parameter int STEP_PRIME = 13
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [dhti_pkg::KEY_W-1:0]           dividend,
  output logic                                 done,
  output logic [$clog2(TABLE_SIZE)-1:0]        rem_size,
  output logic [$clog2(STEP_PRIME)-1:0]        rem_prime
);

  localparam int KW = dhti_pkg::KEY_W;
  localparam int SW = $clog2(TABLE_SIZE);
  localparam int PW = $clog2(STEP_PRIME);
  localparam logic [2*KW-1:0] SCALE = (2*KW)'(1) << KW;
  // floor(2^KW / d): the quotient estimate is exact or one short
  localparam logic [KW-1:0] RECIP_SIZE  = KW'(SCALE / (2*KW)'(TABLE_SIZE));
  localparam logic [KW-1:0] RECIP_PRIME = KW'(SCALE / (2*KW)'(STEP_PRIME));

  logic [2*KW-1:0] prod_size;
  logic [2*KW-1:0] prod_prime;
  logic [KW-1:0]   x_hold;
  logic [KW-1:0]   quo_size;
  logic [KW-1:0]   quo_prime;
  logic [KW-1:0]   diff_size;
  logic [KW-1:0]   diff_prime;
  logic [SW:0]     raw_size;
  logic [PW:0]     raw_prime;
  logic [SW-1:0]   rem_size_next;
  logic [PW-1:0]   rem_prime_next;
  logic            stage1;
  logic            stage2;

  always_comb begin
    quo_size   = prod_size[2*KW-1:KW];
    quo_prime  = prod_prime[2*KW-1:KW];
    diff_size  = x_hold - KW'(quo_size * KW'(TABLE_SIZE));
    diff_prime = x_hold - KW'(quo_prime * KW'(STEP_PRIME));
  end

  // raw remainder is below twice the modulus, one subtract brings it in range
  always_comb begin
    if (raw_size >= (SW+1)'(TABLE_SIZE)) begin
      rem_size_next = SW'(raw_size - (SW+1)'(TABLE_SIZE));
    end else begin
      rem_size_next = SW'(raw_size);
    end
    if (raw_prime >= (PW+1)'(STEP_PRIME)) begin
      rem_prime_next = PW'(raw_prime - (PW+1)'(STEP_PRIME));
    end else begin
      rem_prime_next = PW'(raw_prime);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1 <= 1'b0;
      stage2 <= 1'b0;
      done   <= 1'b0;
    end else begin
      stage1 <= start;
      stage2 <= stage1;
      done   <= stage2;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_size  <= (2*KW)'(dividend) * (2*KW)'(RECIP_SIZE);
      prod_prime <= (2*KW)'(dividend) * (2*KW)'(RECIP_PRIME);
      x_hold     <= dividend;
    end
    if (stage1) begin
      raw_size  <= diff_size[SW:0];
      raw_prime <= diff_prime[PW:0];
    end
    if (stage2) begin
      rem_size  <= rem_size_next;
      rem_prime <= rem_prime_next;
    end
  end

endmodule

[hdl/dhti_datapath.sv]
// datapath: key register, remainder unit, slot table memory, probe position and results
// depends on dhti_pkg and dhti_mod_unit

module dhti_datapath #(
  parameter int TABLE_SIZE = 61,
  parameter int STEP_PRIME = 13
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [dhti_pkg::KEY_W-1:0]        insert_key,
  input  dhti_pkg::cmd_t                    cmd,
  output dhti_pkg::stat_t                   stat,
  output logic [dhti_pkg::STATUS_W-1:0]     status,
  output logic [dhti_pkg::FIELD_W-1:0]      slot_index,
  output logic [dhti_pkg::FIELD_W-1:0]      probe_count
);

  localparam int SW = $clog2(TABLE_SIZE);
  localparam int PW = $clog2(STEP_PRIME);
  localparam int CW = $clog2(TABLE_SIZE + 1);
  localparam bit NEED_REDUCE = (STEP_PRIME >= TABLE_SIZE);

  logic [dhti_pkg::KEY_W-1:0]    key;
  logic [dhti_pkg::KEY_W-1:0]    dividend;
  logic                          mod_done;
  logic [SW-1:0]                 rem_size;
  logic [PW-1:0]                 rem_prime;
  logic [PW:0]                   rem_s_plus;

  logic [SW-1:0]                 home;
  logic [SW-1:0]                 step;
  logic [SW-1:0]                 cur_pos;
  logic [SW-1:0]                 next_pos;
  logic [SW:0]                   pos_sum;
  logic [CW-1:0]                 count;
  logic [SW-1:0]                 clr_addr;

  // table word: used flag above the stored key
  logic [dhti_pkg::KEY_W:0]      table_mem [TABLE_SIZE];
  logic [dhti_pkg::KEY_W:0]      rdata;
  logic [SW-1:0]                 rd_addr;
  logic [SW-1:0]                 wr_addr;
  logic [dhti_pkg::KEY_W:0]      wr_data;
  logic                          mem_we;

  logic [dhti_pkg::STATUS_W-1:0] res_status;
  logic [dhti_pkg::FIELD_W-1:0]  res_slot;
  logic [dhti_pkg::FIELD_W-1:0]  res_count;

  assign rem_s_plus = {1'b0, rem_prime} + (PW+1)'(1);
  assign dividend   = cmd.reduce_start ? dhti_pkg::KEY_W'(rem_s_plus) : insert_key;

  dhti_mod_unit #(
    .TABLE_SIZE (TABLE_SIZE),
    .STEP_PRIME (STEP_PRIME)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.hash_start | cmd.reduce_start),
    .dividend  (dividend),
    .done      (mod_done),
    .rem_size  (rem_size),
    .rem_prime (rem_prime)
  );

  always_comb begin
    pos_sum = {1'b0, cur_pos} + {1'b0, step};
    if (pos_sum >= (SW+1)'(TABLE_SIZE)) begin
      next_pos = SW'(pos_sum - (SW+1)'(TABLE_SIZE));
    end else begin
      next_pos = SW'(pos_sum);
    end
  end

  assign rd_addr = cmd.probe_start ? home : next_pos;
  assign mem_we  = cmd.clear_wr | cmd.write_slot;
  assign wr_addr = cmd.clear_wr ? clr_addr : cur_pos;
  assign wr_data = cmd.clear_wr ? '0 : {1'b1, key};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[wr_addr] <= wr_data;
    end
    rdata <= table_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_wr) begin
      clr_addr <= clr_addr + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      key <= insert_key;
    end
    if (cmd.take_hash) begin
      home <= rem_size;
      step <= SW'(rem_s_plus);
    end
    if (cmd.take_step) begin
      step <= rem_size;
    end
    if (cmd.probe_start) begin
      cur_pos <= home;
      count   <= CW'(1);
    end else if (cmd.probe_next) begin
      cur_pos <= next_pos;
      count   <= count + CW'(1);
    end
    if (cmd.result_load) begin
      res_status <= cmd.result_status;
      res_slot   <= (cmd.result_status == dhti_pkg::ST_FULL) ? '0
                                                             : dhti_pkg::FIELD_W'(cur_pos);
      res_count  <= dhti_pkg::FIELD_W'(count);
    end
    if (cmd.out_load) begin
      status      <= res_status;
      slot_index  <= res_slot;
      probe_count <= res_count;
    end
  end

  always_comb begin
    stat.clear_last  = (clr_addr == SW'(TABLE_SIZE - 1));
    stat.mod_done    = mod_done;
    stat.need_reduce = NEED_REDUCE;
    stat.hit_empty   = !rdata[dhti_pkg::KEY_W];
    stat.hit_match   = (rdata[dhti_pkg::KEY_W-1:0] == key);
    stat.probe_last  = (count == CW'(TABLE_SIZE));
  end

endmodule

[hdl/dhti_ctrl.sv]
// controller: sequences clearing, hashing, probing and the result hand-off
// depends on dhti_pkg; drives the datapath through cmd_t

module dhti_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  dhti_pkg::stat_t  stat,
  output dhti_pkg::cmd_t   cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_HASH   = 3'd2;
  localparam logic [2:0] S_REDUCE = 3'd3;
  localparam logic [2:0] S_START  = 3'd4;
  localparam logic [2:0] S_PROBE  = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_key   = 1'b1;
          cmd.hash_start = 1'b1;
          state_next     = S_HASH;
        end
      end
      S_HASH: begin
        if (stat.mod_done) begin
          cmd.take_hash = 1'b1;
          if (stat.need_reduce) begin
            // step residue still has to be brought below the table size
            cmd.reduce_start = 1'b1;
            state_next       = S_REDUCE;
          end else begin
            state_next = S_START;
          end
        end
      end
      S_REDUCE: begin
        if (stat.mod_done) begin
          cmd.take_step = 1'b1;
          state_next    = S_START;
        end
      end
      S_START: begin
        cmd.probe_start = 1'b1;
        state_next      = S_PROBE;
      end
      S_PROBE: begin
        if (stat.hit_empty) begin
          cmd.write_slot    = 1'b1;
          cmd.result_load   = 1'b1;
          cmd.result_status = dhti_pkg::ST_INSERTED;
          state_next        = S_FINISH;
        end else if (stat.hit_match) begin
          cmd.result_load   = 1'b1;
          cmd.result_status = dhti_pkg::ST_DUPLICATE;
          state_next        = S_FINISH;
        end else if (stat.probe_last) begin
          cmd.result_load   = 1'b1;
          cmd.result_status = dhti_pkg::ST_FULL;
          state_next        = S_FINISH;
        end else begin
          cmd.probe_next = 1'b1;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hdl/double_hash_table_insert.sv]
// Open-addressed hash table insert with double hashing. Each key goes to home slot
// key mod TABLE_SIZE and steps by (key mod STEP_PRIME) + 1; the result reports insert,
// duplicate or full, the slot, and the number of slots probed. After reset all
// TABLE_SIZE slots of the table memory are cleared, one slot a cycle, before the first
// key is taken. One key is handled at a time, with 1 to TABLE_SIZE probes per key and
// one table read per probe on the single table memory. The two remainders come from a
// three-stage reciprocal-multiply pipeline; when STEP_PRIME is not below TABLE_SIZE a
// second pass through it reduces the step. A finished result waits in an output
// register, and the next key is taken while it waits; a result not yet taken holds the
// following one back.
// Depends on dhti_pkg, dhti_key_if, dhti_result_if, dhti_ctrl and dhti_datapath.

module double_hash_table_insert #(
  parameter int TABLE_SIZE = 61,
  parameter int STEP_PRIME = 13
) (
  input  logic          clk,
  input  logic          rst,
  dhti_key_if.sink      keys,
  dhti_result_if.source results
);

  dhti_pkg::cmd_t  cmd;
  dhti_pkg::stat_t stat;

  dhti_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (keys.valid),
    .in_ready  (keys.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dhti_datapath #(
    .TABLE_SIZE (TABLE_SIZE),
    .STEP_PRIME (STEP_PRIME)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .insert_key  (keys.insert_key),
    .cmd         (cmd),
    .stat        (stat),
    .status      (results.status),
    .slot_index  (results.slot_index),
    .probe_count (results.probe_count)
  );

  // a key is only ever written into a slot seen empty
  a_write_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.write_slot |-> stat.hit_empty && !cmd.clear_wr)
    else $error("slot write to a used slot");

  // full is only reported after the last probe
  a_full_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.result_load && cmd.result_status == dhti_pkg::ST_FULL) |-> stat.probe_last)
    else $error("full reported before all probes");

  // one key in flight: no second transfer right after an accepted one
  a_one_key: assert property (@(posedge clk) disable iff (rst)
    (keys.valid && keys.ready) |=> !keys.ready)
    else $error("key accepted while busy");

  // a new result only appears from a result hand-off
  a_out_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(cmd.out_load))
    else $error("result valid without hand-off");

endmodule

[test/tb_double_hash_table_insert.sv]
// self-checking testbench for double_hash_table_insert: keys in, insert outcomes checked
// depends on dhti_pkg, dhti_key_if, dhti_result_if and the block under test

module tb_double_hash_table_insert;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS        = 61;
  localparam int STEP_MOD     = 13;
  localparam int RANDOM_KEYS  = 1800;
  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [dhti_pkg::STATUS_W-1:0] status;
    logic [dhti_pkg::FIELD_W-1:0]  slot;
    logic [dhti_pkg::FIELD_W-1:0]  probes;
  } outcome_t;

  // shadow copy of the table; predicts the outcome of every accepted key
  class table_shadow;
    bit                       used [SLOTS];
    bit [dhti_pkg::KEY_W-1:0] stored [SLOTS];
    int                       fill;
    int                       mismatches;
    outcome_t                 pending_outcomes [$];

    function void note_insert(bit [dhti_pkg::KEY_W-1:0] k);
      int unsigned key_val;
      int unsigned pos;
      int unsigned stride;
      outcome_t    o;
      key_val  = k;
      pos      = key_val % SLOTS;
      stride   = (key_val % STEP_MOD + 1) % SLOTS;
      o.status = dhti_pkg::ST_FULL;
      o.slot   = '0;
      o.probes = dhti_pkg::FIELD_W'(SLOTS);
      for (int i = 0; i < SLOTS; i++) begin
        if (!used[pos]) begin
          used[pos]   = 1'b1;
          stored[pos] = k;
          fill++;
          o.status = dhti_pkg::ST_INSERTED;
          o.slot   = dhti_pkg::FIELD_W'(pos);
          o.probes = dhti_pkg::FIELD_W'(i + 1);
          break;
        end
        if (stored[pos] == k) begin
          o.status = dhti_pkg::ST_DUPLICATE;
          o.slot   = dhti_pkg::FIELD_W'(pos);
          o.probes = dhti_pkg::FIELD_W'(i + 1);
          break;
        end
        pos += stride;
        if (pos >= SLOTS) pos -= SLOTS;
      end
      pending_outcomes.push_back(o);
    endfunction

    function void check_outcome(outcome_t got);
      outcome_t want;
      if (pending_outcomes.size() == 0) begin
        $display("%0t: result with nothing expected: status %0d slot %0d probes %0d",
                 $time, got.status, got.slot, got.probes);
        mismatches++;
        return;
      end
      want = pending_outcomes.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        mismatches++;
      end
      if (got.slot !== want.slot) begin
        $display("%0t: slot_index expected %0d actual %0d", $time, want.slot, got.slot);
        mismatches++;
      end
      if (got.probes !== want.probes) begin
        $display("%0t: probe_count expected %0d actual %0d", $time, want.probes, got.probes);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic steady;
  int   cycles = 0;

  table_shadow              shadow = new();
  logic [dhti_pkg::KEY_W-1:0] sent_keys [$];

  // zero, all ones, home collisions and their repeats
  logic [dhti_pkg::KEY_W-1:0] opening_keys [16] = '{
    31'd0, 31'd0, 31'd61, 31'd122, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd1, 31'd60,
    31'd13, 31'd12, 31'd61, 31'd122, 31'd1, 31'h2AAA_AAAA, 31'h5555_5555, 31'd183
  };

  dhti_key_if    keys_ch ();
  dhti_result_if res_ch ();

  double_hash_table_insert #(
    .TABLE_SIZE (SLOTS),
    .STEP_PRIME (STEP_MOD)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .keys    (keys_ch),
    .results (res_ch)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** double_hash_table_insert: FAILED **");
      $finish;
    end
  end

  // every transfer on either channel goes to the shadow table
  always @(posedge clk) begin
    if (!rst) begin
      if (keys_ch.valid && keys_ch.ready) shadow.note_insert(keys_ch.insert_key);
      if (res_ch.valid && res_ch.ready)
        shadow.check_outcome({res_ch.status, res_ch.slot_index, res_ch.probe_count});
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // fresh key: fully random, sharing the home slot of an earlier key, or small
  function automatic logic [dhti_pkg::KEY_W-1:0] fresh_key();
    logic [dhti_pkg::KEY_W-1:0] base;
    case ($urandom_range(0, 2))
      0: return dhti_pkg::KEY_W'($urandom);
      1: begin
        if (sent_keys.size() == 0) return dhti_pkg::KEY_W'($urandom);
        base = sent_keys[$urandom_range(0, sent_keys.size() - 1)];
        return dhti_pkg::KEY_W'(base % SLOTS + SLOTS * $urandom_range(0, 35_000_000));
      end
      default: return dhti_pkg::KEY_W'($urandom_range(0, 4000));
    endcase
  endfunction

  task automatic send_key(input logic [dhti_pkg::KEY_W-1:0] k);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      keys_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    keys_ch.valid      <= 1'b1;
    keys_ch.insert_key <= k;
    sent_keys.push_back(k);
    @(posedge clk);
    while (!keys_ch.ready) @(posedge clk);
  endtask

  initial begin
    int gap;
    int burst;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      burst = $urandom_range(1, 6);
      repeat (burst) @(posedge clk);
    end
  end

  initial begin
    logic [dhti_pkg::KEY_W-1:0] k;
    bit                         pick_new;
    steady = 1'b0;
    rst <= 1'b1;
    keys_ch.valid      <= 1'b0;
    keys_ch.insert_key <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (opening_keys[i]) send_key(opening_keys[i]);

    // fill the table slowly so that long probe chains and repeats come before it is full
    for (int n = 0; n < RANDOM_KEYS; n++) begin
      steady = (n >= 700 && n < 800);
      if (shadow.fill < SLOTS)
        pick_new = ($urandom_range(0, 99) < 6) || (sent_keys.size() == 0);
      else
        pick_new = $urandom_range(0, 1);
      if (pick_new) k = fresh_key();
      else          k = sent_keys[$urandom_range(0, sent_keys.size() - 1)];
      send_key(k);
    end
    keys_ch.valid <= 1'b0;
    steady = 1'b0;

    while (shadow.pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.mismatches == 0)
      $display("** double_hash_table_insert: PASSED **");
    else
      $display("** double_hash_table_insert: FAILED **");
    $finish;
  end

endmodule
